// ===== rtl/vtd_pkg.sv =====
// Shared constants, types and helpers for the vertex tuple dedup block.
// No dependencies.
package vtd_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int MAX_TUPLE   = 8;
  localparam int INDEX_BITS  = 16;
  localparam int FIELD_W     = 16;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int TW_W        = 4;
  localparam int VIDX_W      = 10;
  localparam int ROW_W       = MAX_TUPLE * FIELD_W;
  localparam int Q_DEPTH     = 2;
  localparam int Q_AW        = $clog2(Q_DEPTH);

  typedef logic [MAX_TUPLE-1:0][FIELD_W-1:0] key_t;

  typedef struct packed {
    logic                 first;
    logic [MAX_TUPLE-1:0] lane_mask;
    key_t                 key;
  } req_t;

  // Lanes that take part for a given width register value.
  function automatic logic [MAX_TUPLE-1:0] lane_mask_of(input logic [TW_W-1:0] tw);
    logic [MAX_TUPLE-1:0] m;
    logic [TW_W:0]        n;
    n = {1'b0, tw};
    if (n == '0) n = (TW_W+1)'(1);
    if (n > (TW_W+1)'(MAX_TUPLE)) n = (TW_W+1)'(MAX_TUPLE);
    for (int k = 0; k < MAX_TUPLE; k++) begin
      m[k] = ((TW_W+1)'(k) < n);
    end
    return m;
  endfunction

  function automatic logic [FIELD_W-1:0] keep_index(input logic [FIELD_W-1:0] v);
    logic [FIELD_W-1:0] msk;
    msk = (INDEX_BITS >= FIELD_W) ? '1 : FIELD_W'((1 << INDEX_BITS) - 1);
    return v & msk;
  endfunction

endpackage

// ===== rtl/vertex_tuple_dedup_top.sv =====
// Vertex tuple dedup: top level joining front end and scanning back end.
// Depends on vtd_pkg, vtd_front and vtd_back.
//
// Usage:
//   Drive first and idx_0..idx_7 with start high; the request is taken at a
//   clock edge where busy is low. Up to two requests queue ahead of the
//   back end, which handles one at a time.
//   Each request yields one result: vert_num, is_new and table_full are
//   valid for the single cycle in which done is high. The receiver cannot
//   stall; results simply appear.
//   tuple_width is written through tuple_width_we / tuple_width_data while
//   the block is idle; it is sampled when a request is taken.
//   The back end reads one stored tuple per cycle from its RAM port while
//   scanning. With the back end idle, a request leaves the queue at the
//   edge after it is taken. A request scans the stored tuples up to and
//   including the match on a hit, or all of them (the vertex count, at
//   most 1024) on a miss; a first request scans nothing. The back end
//   takes the next request only once the current one is done. Reset
//   empties the queue and the table and sets tuple_width to 1; no
//   clearing pass is needed.
module vertex_tuple_dedup_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         tuple_width_we,
  input  logic [vtd_pkg::TW_W-1:0]     tuple_width_data,
  input  logic                         first,
  input  logic [vtd_pkg::FIELD_W-1:0]  idx_0,
  input  logic [vtd_pkg::FIELD_W-1:0]  idx_1,
  input  logic [vtd_pkg::FIELD_W-1:0]  idx_2,
  input  logic [vtd_pkg::FIELD_W-1:0]  idx_3,
  input  logic [vtd_pkg::FIELD_W-1:0]  idx_4,
  input  logic [vtd_pkg::FIELD_W-1:0]  idx_5,
  input  logic [vtd_pkg::FIELD_W-1:0]  idx_6,
  input  logic [vtd_pkg::FIELD_W-1:0]  idx_7,
  output logic                         done,
  output logic [vtd_pkg::VIDX_W-1:0]   vert_num,
  output logic                         is_new,
  output logic                         table_full
);
  import vtd_pkg::*;

  key_t key_in;
  logic q_valid;
  logic q_pop;
  req_t q_req;

  assign key_in = {idx_7, idx_6, idx_5, idx_4, idx_3, idx_2, idx_1, idx_0};

  vtd_front u_front (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .tuple_width_we   (tuple_width_we),
    .tuple_width_data (tuple_width_data),
    .first            (first),
    .key_in           (key_in),
    .q_valid          (q_valid),
    .q_req            (q_req),
    .q_pop            (q_pop)
  );

  vtd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_req        (q_req),
    .q_pop        (q_pop),
    .done         (done),
    .vert_num     (vert_num),
    .is_new       (is_new),
    .table_full   (table_full)
  );

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(is_new && table_full))
    else $error("is_new and table_full both set");

  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    (done && table_full) |-> (vert_num == '0))
    else $error("full result with nonzero index");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> !done)
    else $error("result in cycle after request pop");

endmodule

// ===== rtl/vtd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vtd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// ===== rtl/vtd_front.sv =====
// Front end: width register, request capture and a two-entry request queue.
// Depends on vtd_pkg.
module vtd_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         tuple_width_we,
  input  logic [vtd_pkg::TW_W-1:0]     tuple_width_data,
  input  logic                         first,
  input  vtd_pkg::key_t                key_in,
  output logic                         q_valid,
  output vtd_pkg::req_t                q_req,
  input  logic                         q_pop
);
  import vtd_pkg::*;

  logic [TW_W-1:0] tuple_width;
  req_t            slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   fill;
  logic            push;
  req_t            req_new;

  assign busy    = (fill == (Q_AW+1)'(Q_DEPTH));
  assign push    = start && !busy;
  assign q_valid = (fill != '0);
  assign q_req   = slots[rd_ptr];

  always_comb begin
    req_new.first     = first;
    req_new.lane_mask = lane_mask_of(tuple_width);
    for (int k = 0; k < MAX_TUPLE; k++) begin
      req_new.key[k] = keep_index(key_in[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tuple_width <= TW_W'(1);
      wr_ptr      <= '0;
      rd_ptr      <= '0;
      fill        <= '0;
    end else begin
      if (tuple_width_we) tuple_width <= tuple_width_data;
      if (push) wr_ptr <= wr_ptr + Q_AW'(1);
      if (q_pop) rd_ptr <= rd_ptr + Q_AW'(1);
      if (push && !q_pop) fill <= fill + (Q_AW+1)'(1);
      else if (q_pop && !push) fill <= fill - (Q_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= req_new;
  end

endmodule

// ===== rtl/vtd_back.sv =====
// Back end: scans the stored tuples in first-seen order and appends misses.
// Depends on vtd_pkg and vtd_ram.
module vtd_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  vtd_pkg::req_t              q_req,
  output logic                       q_pop,
  output logic                       done,
  output logic [vtd_pkg::VIDX_W-1:0] vert_num,
  output logic                       is_new,
  output logic                       table_full
);
  import vtd_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic              state;
  req_t              cur;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  ptr;
  logic              pend;
  logic [ADDR_W-1:0] pend_ptr;
  logic [ROW_W-1:0]  rdata;
  key_t              row;
  logic              hit;
  logic              rd_en;
  logic              wr_en;

  assign row   = key_t'(rdata);
  assign q_pop = (state == S_IDLE) && q_valid;

  always_comb begin
    hit = 1'b1;
    for (int k = 0; k < MAX_TUPLE; k++) begin
      if (cur.lane_mask[k] && (row[k] != cur.key[k])) hit = 1'b0;
    end
  end

  assign rd_en = (state == S_SCAN) && !(pend && hit) && (ptr < count);
  assign wr_en = (state == S_SCAN) && !(pend && hit) && !(ptr < count)
                 && (count != CNT_W'(TABLE_DEPTH));

  vtd_ram #(.WIDTH(ROW_W), .DEPTH(TABLE_DEPTH)) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count[ADDR_W-1:0]),
    .wdata (ROW_W'(cur.key)),
    .re    (rd_en),
    .raddr (ptr[ADDR_W-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= (state == S_SCAN) && ((pend && hit) || !(ptr < count));
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            if (q_req.first) count <= '0;
            pend  <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          priority if (pend && hit) begin
            state <= S_IDLE;
          end else if (ptr < count) begin
            pend <= 1'b1;
          end else begin
            // miss: append unless the table is full
            if (count != CNT_W'(TABLE_DEPTH)) count <= count + CNT_W'(1);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_req;
      ptr <= '0;
    end else if (rd_en) begin
      ptr      <= ptr + CNT_W'(1);
      pend_ptr <= ptr[ADDR_W-1:0];
    end
    if (state == S_SCAN) begin
      if (pend && hit) begin
        vert_num   <= VIDX_W'(pend_ptr);
        is_new     <= 1'b0;
        table_full <= 1'b0;
      end else if (!(ptr < count)) begin
        if (count == CNT_W'(TABLE_DEPTH)) begin
          vert_num   <= '0;
          is_new     <= 1'b0;
          table_full <= 1'b1;
        end else begin
          vert_num   <= VIDX_W'(count);
          is_new     <= 1'b1;
          table_full <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== tb/vtd_dedup_checker.sv =====
// Checker for the vertex tuple dedup block: tracks the width register, predicts each
// request's vertex number from its own copy of the surface table and compares results.
// Depends on vtd_pkg.
`timescale 1ns / 1ps
module vtd_dedup_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  logic                       tuple_width_we,
  input  logic [vtd_pkg::TW_W-1:0]   tuple_width_data,
  input  logic                       first,
  input  logic [vtd_pkg::FIELD_W-1:0] idx_0,
  input  logic [vtd_pkg::FIELD_W-1:0] idx_1,
  input  logic [vtd_pkg::FIELD_W-1:0] idx_2,
  input  logic [vtd_pkg::FIELD_W-1:0] idx_3,
  input  logic [vtd_pkg::FIELD_W-1:0] idx_4,
  input  logic [vtd_pkg::FIELD_W-1:0] idx_5,
  input  logic [vtd_pkg::FIELD_W-1:0] idx_6,
  input  logic [vtd_pkg::FIELD_W-1:0] idx_7,
  input  logic                       done,
  input  logic [vtd_pkg::VIDX_W-1:0] vert_num,
  input  logic                       is_new,
  input  logic                       table_full,
  output int                         fail_count,
  output int                         pending_count
);
  import vtd_pkg::*;

  typedef struct {
    logic [VIDX_W-1:0] vidx;
    logic              fresh;
    logic              full;
  } vertex_result_t;

  key_t           surface_rows [TABLE_DEPTH];
  int unsigned    vertex_total;
  logic [TW_W-1:0] width_reg;
  vertex_result_t awaited_vertices [$];

  // Look the tuple up in the current surface, storing it when new and room is left.
  function automatic vertex_result_t lookup_vertex(input logic first_in, input key_t key);
    vertex_result_t r;
    int unsigned    lanes;
    logic           same;
    lanes = (width_reg == 0) ? 1 : (width_reg > MAX_TUPLE) ? MAX_TUPLE : width_reg;
    if (first_in) vertex_total = 0;
    for (int unsigned i = 0; i < vertex_total; i++) begin
      same = 1'b1;
      for (int unsigned k = 0; k < lanes; k++) begin
        if (surface_rows[i][k] != key[k]) same = 1'b0;
      end
      if (same) begin
        r.vidx  = VIDX_W'(i);
        r.fresh = 1'b0;
        r.full  = 1'b0;
        return r;
      end
    end
    if (vertex_total >= TABLE_DEPTH) begin
      r.vidx  = '0;
      r.fresh = 1'b0;
      r.full  = 1'b1;
      return r;
    end
    surface_rows[vertex_total] = key;
    r.vidx  = VIDX_W'(vertex_total);
    r.fresh = 1'b1;
    r.full  = 1'b0;
    vertex_total++;
    return r;
  endfunction

  always @(posedge clk) begin
    key_t           key;
    vertex_result_t want;
    if (rst) begin
      vertex_total = 0;
      width_reg    = TW_W'(1);
      awaited_vertices.delete();
      fail_count    <= 0;
      pending_count <= 0;
    end else begin
      if (done) begin
        if (awaited_vertices.size() == 0) begin
          $error("result with no request outstanding: vert_num %0d", vert_num);
          fail_count <= fail_count + 1;
        end else begin
          want = awaited_vertices.pop_front();
          if (vert_num !== want.vidx || is_new !== want.fresh ||
              table_full !== want.full) begin
            fail_count <= fail_count + 1;
            if (vert_num !== want.vidx)
              $error("vert_num: expected %0d, got %0d", want.vidx, vert_num);
            if (is_new !== want.fresh)
              $error("is_new: expected %0b, got %0b", want.fresh, is_new);
            if (table_full !== want.full)
              $error("table_full: expected %0b, got %0b", want.full, table_full);
          end
        end
      end
      // width is sampled with the request, so a write at this edge applies after it
      if (start && !busy) begin
        key = {idx_7, idx_6, idx_5, idx_4, idx_3, idx_2, idx_1, idx_0};
        awaited_vertices.insert(awaited_vertices.size(), lookup_vertex(first, key));
      end
      if (tuple_width_we) width_reg = tuple_width_data;
      pending_count <= awaited_vertices.size();
    end
  end

endmodule

// ===== tb/tb_vertex_tuple_dedup_top.sv =====
// Testbench top for vertex_tuple_dedup_top: drives directed and random requests and
// width register writes, and gives the verdict from vtd_dedup_checker.
// Depends on vtd_pkg, vertex_tuple_dedup_top and vtd_dedup_checker.
`timescale 1ns / 1ps
module tb_vertex_tuple_dedup_top;
  import vtd_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic               tuple_width_we;
  logic [TW_W-1:0]    tuple_width_data;
  logic               first;
  logic [FIELD_W-1:0] idx [MAX_TUPLE];
  logic               done;
  logic [VIDX_W-1:0]  vert_num;
  logic               is_new;
  logic               table_full;
  int                 fail_count;
  int                 pending_count;
  int                 idle_pct;
  int                 quiet_cycles;

  vertex_tuple_dedup_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .tuple_width_we(tuple_width_we), .tuple_width_data(tuple_width_data),
    .first(first), .idx_0(idx[0]), .idx_1(idx[1]), .idx_2(idx[2]), .idx_3(idx[3]),
    .idx_4(idx[4]), .idx_5(idx[5]), .idx_6(idx[6]), .idx_7(idx[7]),
    .done(done), .vert_num(vert_num), .is_new(is_new), .table_full(table_full)
  );

  vtd_dedup_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .tuple_width_we(tuple_width_we), .tuple_width_data(tuple_width_data),
    .first(first), .idx_0(idx[0]), .idx_1(idx[1]), .idx_2(idx[2]), .idx_3(idx[3]),
    .idx_4(idx[4]), .idx_5(idx[5]), .idx_6(idx[6]), .idx_7(idx[7]),
    .done(done), .vert_num(vert_num), .is_new(is_new), .table_full(table_full),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Abort when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input logic first_in, input logic [FIELD_W-1:0] v [MAX_TUPLE]);
    @(negedge clk);
    start = 1'b1;
    first = first_in;
    for (int k = 0; k < MAX_TUPLE; k++) idx[k] = v[k];
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(4)) @(negedge clk);
    end
  endtask

  // Write the width register once every request has been answered.
  task automatic write_width(input logic [TW_W-1:0] w);
    @(negedge clk);
    start = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    tuple_width_we   = 1'b1;
    tuple_width_data = w;
    @(negedge clk);
    tuple_width_we = 1'b0;
  endtask

  task automatic send_random(input int count);
    logic [FIELD_W-1:0] v [MAX_TUPLE];
    for (int n = 0; n < count; n++) begin
      for (int k = 0; k < MAX_TUPLE; k++)
        v[k] = ($urandom_range(9) < 7) ? FIELD_W'($urandom_range(2)) : FIELD_W'($urandom);
      send_request(n == 0 || $urandom_range(15) == 0, v);
    end
  endtask

  logic [FIELD_W-1:0] row [MAX_TUPLE];
  logic [TW_W-1:0]    widths [6] = '{4'd0, 4'd1, 4'd8, 4'd15, 4'd3, 4'd5};

  initial begin
    rst              = 1'b1;
    start            = 1'b0;
    first            = 1'b0;
    tuple_width_we   = 1'b0;
    tuple_width_data = '0;
    idle_pct         = 26;
    for (int k = 0; k < MAX_TUPLE; k++) idx[k] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Field extremes at the full width, then repeats of them.
    write_width(4'd8);
    for (int k = 0; k < MAX_TUPLE; k++) row[k] = '0;
    send_request(1'b1, row);
    for (int k = 0; k < MAX_TUPLE; k++) row[k] = '1;
    send_request(1'b0, row);
    send_request(1'b0, row);
    row[7] = 16'h7FFF;
    send_request(1'b0, row);
    for (int k = 0; k < MAX_TUPLE; k++) row[k] = '0;
    send_request(1'b0, row);
    // Narrow the width mid-surface: only lanes 0 and 1 are compared now.
    write_width(4'd2);
    row[7] = 16'h1234;
    send_request(1'b0, row);
    for (int k = 0; k < MAX_TUPLE; k++) row[k] = '1;
    row[2] = 16'h0;
    send_request(1'b0, row);
    // A first request restarts numbering even for a known tuple.
    send_request(1'b1, row);
    send_request(1'b0, row);

    // Fill the table at width one, then overflow it.
    write_width(4'd1);
    for (int k = 0; k < MAX_TUPLE; k++) row[k] = '0;
    for (int n = 0; n < TABLE_DEPTH; n++) begin
      row[0] = FIELD_W'(n * 37 + 5);
      send_request(n == 0, row);
    end
    row[0] = 16'hFFFF;
    send_request(1'b0, row);
    row[0] = 16'd5;
    send_request(1'b0, row);
    row[0] = FIELD_W'((TABLE_DEPTH - 1) * 37 + 5);
    send_request(1'b0, row);
    row[0] = 16'h8000;
    send_request(1'b0, row);
    send_request(1'b1, row);

    // Random surfaces: sender idles rarely, then often, then not at all.
    for (int p = 0; p < 6; p++) begin
      idle_pct = (p < 2) ? 26 : (p < 4) ? 67 : 0;
      write_width(widths[p]);
      send_random(70);
    end

    @(negedge clk);
    start = 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
